@@ hdl/bmpblit_pkg.sv @@
// Shared widths and register indexes for the bitmap-to-framebuffer blitter.
package bmpblit_pkg;

    localparam int BYTE_W     = 8;
    localparam int DIM_REG_W  = 12;
    localparam int XSTART_W   = 10;
    localparam int YSTART_W   = 9;
    localparam int ADDR_W     = 19;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_START      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_START      = 2'd3;

    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;

endpackage

@@ hdl/bmp24_to_framebuffer_blit.sv @@
// Streams 24-bit bottom-up bitmap bytes into framebuffer address and color items.
// An accepted red byte's result item is registered in the output register, if the pixel lies on screen.
// Throughput: one byte per cycle while pixel_stall is low (it rises when a held result meets
// result_stall); the output register drains while the next byte is taken.
// Reset: counters, flags and result valid clear; width and height reset to 1,
// start offsets to 0. No clearing pass is needed.
module bmp24_to_framebuffer_blit #(
    parameter int FB_WIDTH      = 800,
    parameter int FB_HEIGHT     = 480,
    parameter int MAX_IMAGE_DIM = 2048
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bmpblit_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmpblit_pkg::CFG_DATA_W-1:0]   cfg_data,
    // byte stream
    input  logic                                 pixel_valid,
    output logic                                 pixel_stall,
    input  logic [bmpblit_pkg::BYTE_W-1:0]       pixel_byte,
    input  logic                                 image_start,
    // result stream
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [bmpblit_pkg::ADDR_W-1:0]       fb_address,
    output logic [bmpblit_pkg::COLOR_W-1:0]      pixel_color
);

    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
    localparam int CNT_W = (MAX_IMAGE_DIM > 1) ? $clog2(MAX_IMAGE_DIM) : 1;
    localparam int ROW_W = ((DIM_W > bmpblit_pkg::YSTART_W) ? DIM_W
                            : bmpblit_pkg::YSTART_W) + 1;
    localparam int COL_W = ((DIM_W > bmpblit_pkg::XSTART_W) ? DIM_W
                            : bmpblit_pkg::XSTART_W) + 1;
    localparam int CMP_W = bmpblit_pkg::DIM_REG_W + 1;

    // configuration registers
    logic [bmpblit_pkg::DIM_REG_W-1:0] image_width_reg;
    logic [bmpblit_pkg::DIM_REG_W-1:0] image_height_reg;
    logic [bmpblit_pkg::XSTART_W-1:0]  x_start_reg;
    logic [bmpblit_pkg::YSTART_W-1:0]  y_start_reg;

    // stream state
    logic [1:0]                     byte_phase_reg, byte_phase_next;
    logic [CNT_W-1:0]               column_count_reg, column_count_next;
    logic [CNT_W-1:0]               row_count_reg, row_count_next;
    logic [1:0]                     pad_count_reg, pad_count_next;
    logic [bmpblit_pkg::BYTE_W-1:0] blue_hold_reg, blue_hold_next;
    logic [bmpblit_pkg::BYTE_W-1:0] green_hold_reg, green_hold_next;
    logic                           image_done_reg, image_done_next;

    // result register
    logic                              result_valid_reg, result_valid_next;
    logic [bmpblit_pkg::ADDR_W-1:0]    fb_address_reg, fb_address_next;
    logic [bmpblit_pkg::COLOR_W-1:0]   pixel_color_reg, pixel_color_next;

    logic             accept;
    logic [DIM_W-1:0] w_dim, h_dim;
    logic [DIM_W-1:0] col, row;
    logic [ROW_W-1:0] disp_row;
    logic [COL_W-1:0] disp_col;
    logic             on_screen;
    logic [31:0]      addr_full;

    // phase/counter values after an optional start clear
    logic [1:0]                     phase_c;
    logic [CNT_W-1:0]               column_c, row_c;
    logic [1:0]                     pad_c;
    logic [bmpblit_pkg::BYTE_W-1:0] blue_c, green_c;
    logic                           done_c;

    assign cfg_ready    = 1'b1;
    assign pixel_stall  = result_valid_reg && result_stall;
    assign accept       = pixel_valid && !pixel_stall;
    assign result_valid = result_valid_reg;
    assign fb_address   = fb_address_reg;
    assign pixel_color  = pixel_color_reg;

    // clamp the dimensions into 1..MAX_IMAGE_DIM
    always_comb
    begin
        if (image_width_reg == '0)
            w_dim = DIM_W'(1);
        else if (CMP_W'(image_width_reg) > CMP_W'(MAX_IMAGE_DIM))
            w_dim = DIM_W'(MAX_IMAGE_DIM);
        else
            w_dim = DIM_W'(image_width_reg);

        if (image_height_reg == '0)
            h_dim = DIM_W'(1);
        else if (CMP_W'(image_height_reg) > CMP_W'(MAX_IMAGE_DIM))
            h_dim = DIM_W'(MAX_IMAGE_DIM);
        else
            h_dim = DIM_W'(image_height_reg);
    end

    always_comb
    begin
        if (image_start)
        begin
            phase_c  = bmpblit_pkg::PHASE_BLUE;
            column_c = '0;
            row_c    = '0;
            pad_c    = '0;
            blue_c   = '0;
            green_c  = '0;
            done_c   = 1'b0;
        end
        else
        begin
            phase_c  = byte_phase_reg;
            column_c = column_count_reg;
            row_c    = row_count_reg;
            pad_c    = pad_count_reg;
            blue_c   = blue_hold_reg;
            green_c  = green_hold_reg;
            done_c   = image_done_reg;
        end

        // hold position inside the image even if the size shrank mid-image
        col = (DIM_W'(column_c) >= w_dim) ? (w_dim - DIM_W'(1)) : DIM_W'(column_c);
        row = (DIM_W'(row_c) >= h_dim) ? (h_dim - DIM_W'(1)) : DIM_W'(row_c);

        // flip the row: file rows run bottom-up
        disp_row  = ROW_W'(h_dim - DIM_W'(1) - row) + ROW_W'(y_start_reg);
        disp_col  = COL_W'(col) + COL_W'(x_start_reg);
        on_screen = (32'(disp_row) < 32'(FB_HEIGHT)) && (32'(disp_col) < 32'(FB_WIDTH));
        addr_full = 32'(disp_row) * 32'(FB_WIDTH) + 32'(disp_col);
    end

    always_comb
    begin
        byte_phase_next   = byte_phase_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        pad_count_next    = pad_count_reg;
        blue_hold_next    = blue_hold_reg;
        green_hold_next   = green_hold_reg;
        image_done_next   = image_done_reg;
        fb_address_next   = fb_address_reg;
        pixel_color_next  = pixel_color_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (accept)
        begin
            byte_phase_next   = phase_c;
            column_count_next = column_c;
            row_count_next    = row_c;
            pad_count_next    = pad_c;
            blue_hold_next    = blue_c;
            green_hold_next   = green_c;
            image_done_next   = done_c;

            if (done_c)
            begin
                // drop bytes after the image until the next start
            end
            else if (pad_c != 2'd0)
            begin
                pad_count_next = pad_c - 2'd1;
            end
            else if (phase_c == bmpblit_pkg::PHASE_BLUE)
            begin
                blue_hold_next  = pixel_byte;
                byte_phase_next = bmpblit_pkg::PHASE_GREEN;
            end
            else if (phase_c == bmpblit_pkg::PHASE_GREEN)
            begin
                green_hold_next = pixel_byte;
                byte_phase_next = bmpblit_pkg::PHASE_RED;
            end
            else
            begin
                byte_phase_next = bmpblit_pkg::PHASE_BLUE;
                if (on_screen)
                begin
                    result_valid_next = 1'b1;
                    fb_address_next   = addr_full[bmpblit_pkg::ADDR_W-1:0];
                    pixel_color_next  = {pixel_byte, green_c, blue_c};
                end

                // end of row: skip padding, advance row or finish the image
                if ((col + DIM_W'(1)) >= w_dim)
                begin
                    column_count_next = '0;
                    pad_count_next    = w_dim[1:0];
                    if ((row + DIM_W'(1)) >= h_dim)
                    begin
                        image_done_next = 1'b1;
                        row_count_next  = '0;
                    end
                    else
                    begin
                        row_count_next = CNT_W'(row + DIM_W'(1));
                    end
                end
                else
                begin
                    column_count_next = CNT_W'(col + DIM_W'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bmpblit_pkg::DIM_REG_W'(1);
            image_height_reg <= bmpblit_pkg::DIM_REG_W'(1);
            x_start_reg      <= '0;
            y_start_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bmpblit_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                bmpblit_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                bmpblit_pkg::CFG_X_START:
                    x_start_reg <= cfg_data[bmpblit_pkg::XSTART_W-1:0];
                bmpblit_pkg::CFG_Y_START:
                    y_start_reg <= cfg_data[bmpblit_pkg::YSTART_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg   <= bmpblit_pkg::PHASE_BLUE;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pad_count_reg    <= '0;
            blue_hold_reg    <= '0;
            green_hold_reg   <= '0;
            image_done_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_phase_reg   <= byte_phase_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            pad_count_reg    <= pad_count_next;
            blue_hold_reg    <= blue_hold_next;
            green_hold_reg   <= green_hold_next;
            image_done_reg   <= image_done_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fb_address_reg  <= fb_address_next;
        pixel_color_reg <= pixel_color_next;
    end

endmodule
